@@ hdl/tsd_pkg.sv @@
// Shared types and constants of the touch swipe detector.
`default_nettype none

package tsd_pkg;

    localparam int POS_W    = 12;
    localparam int TIME_W   = 32;
    localparam int VEL_W    = 32;
    localparam int GEST_W   = 3;
    localparam int EV_W     = 2;
    localparam int THR_W    = 8;
    localparam int Q_FRAC   = 16;
    localparam int ENTRY_W  = 2 * POS_W + TIME_W;
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 40;

    localparam logic [EV_W-1:0] EV_PRESS   = 2'd0;
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd1;
    localparam logic [EV_W-1:0] EV_MOVE    = 2'd2;
    localparam logic [EV_W-1:0] EV_NONE    = 2'd3;

    localparam logic [GEST_W-1:0] GEST_NONE  = 3'd0;
    localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd1;
    localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd2;
    localparam logic [GEST_W-1:0] GEST_DOWN  = 3'd3;
    localparam logic [GEST_W-1:0] GEST_UP    = 3'd4;

    localparam logic [THR_W-1:0] THR_RESET = 8'd20;

    localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_EVAL,
        S_WALK,
        S_CLASS,
        S_RATE,
        S_DIV,
        S_VEL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic update;
        logic walk_start;
        logic classify;
        logic div_start;
        logic vel_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic enough_pts;
        logic walk_done;
        logic locked;
        logic span_zero;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ hdl/tsd_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

module tsd_div #(
    parameter int DIVD_W = 34
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [DIVD_W-1:0]                i_dividend,
    input  wire  [tsd_pkg::TIME_W-1:0]       i_divisor,
    output logic                             o_busy,
    output logic [DIVD_W-1:0]                o_quotient
);

    localparam int REM_W = tsd_pkg::TIME_W + 1;
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [REM_W-1:0]            r_rem;
    logic [DIVD_W-1:0]           r_quo;
    logic [tsd_pkg::TIME_W-1:0]  r_div;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] div_x;
    logic             fits;

    assign rem_sh = {r_rem[REM_W-2:0], r_quo[DIVD_W-1]};
    assign div_x  = {1'b0, r_div};
    assign fits   = (rem_sh >= div_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - div_x) : rem_sh;
            r_quo <= {r_quo[DIVD_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ hdl/tsd_ctrl.sv @@
// Sequencer of the swipe detector: steps one touch report through the datapath.
`default_nettype none

module tsd_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output tsd_pkg::t_cmd   o_cmd,
    input  tsd_pkg::t_stat  i_stat
);

    tsd_pkg::t_state r_state;
    tsd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsd_pkg::S_IDLE: begin
                if (i_in_valid) n_state = tsd_pkg::S_UPDATE;
            end
            tsd_pkg::S_UPDATE: n_state = tsd_pkg::S_EVAL;
            tsd_pkg::S_EVAL: begin
                n_state = i_stat.enough_pts ? tsd_pkg::S_WALK : tsd_pkg::S_DONE;
            end
            tsd_pkg::S_WALK: begin
                if (i_stat.walk_done) n_state = tsd_pkg::S_CLASS;
            end
            tsd_pkg::S_CLASS: n_state = tsd_pkg::S_RATE;
            tsd_pkg::S_RATE: begin
                if (!i_stat.locked) begin
                    n_state = tsd_pkg::S_DONE;
                end else if (i_stat.span_zero) begin
                    n_state = tsd_pkg::S_VEL;
                end else begin
                    n_state = tsd_pkg::S_DIV;
                end
            end
            tsd_pkg::S_DIV: begin
                if (!i_stat.div_busy) n_state = tsd_pkg::S_VEL;
            end
            tsd_pkg::S_VEL: n_state = tsd_pkg::S_DONE;
            tsd_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = tsd_pkg::S_IDLE;
            end
            default: n_state = tsd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tsd_pkg::S_IDLE:   o_in_ready = 1'b1;
            tsd_pkg::S_UPDATE: o_cmd.update = 1'b1;
            tsd_pkg::S_EVAL:   o_cmd.walk_start = i_stat.enough_pts;
            tsd_pkg::S_WALK:   ;
            tsd_pkg::S_CLASS:  o_cmd.classify = 1'b1;
            tsd_pkg::S_RATE:   o_cmd.div_start = i_stat.locked && !i_stat.span_zero;
            tsd_pkg::S_DIV:    ;
            tsd_pkg::S_VEL:    o_cmd.vel_load = 1'b1;
            tsd_pkg::S_DONE:   o_cmd.out_load = i_stat.out_free;
            default:           ;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/tsd_dp.sv @@
// Datapath: touch history ring, displacement sums, classification, velocity, output register.
`default_nettype none

module tsd_dp #(
    parameter int HISTORY_DEPTH = 16,
    parameter int MIN_POINTS    = 5
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_accept,
    input  wire  [tsd_pkg::EV_W-1:0]           i_event,
    input  wire  [tsd_pkg::POS_W-1:0]          i_pos_x,
    input  wire  [tsd_pkg::POS_W-1:0]          i_pos_y,
    input  wire  [tsd_pkg::TIME_W-1:0]         i_time,
    input  wire                                i_cfg_we,
    input  wire  [tsd_pkg::THR_W-1:0]          i_cfg_wdata,
    input  tsd_pkg::t_cmd                      i_cmd,
    output tsd_pkg::t_stat                     o_stat,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [tsd_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = tsd_pkg::POS_W + AW + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int DIVD_W = MAG_W + tsd_pkg::Q_FRAC;
    localparam int QX_W   = (DIVD_W > 33) ? DIVD_W : 33;
    localparam int PAD_W  = tsd_pkg::OUT_DATA_W - tsd_pkg::GEST_W - tsd_pkg::VEL_W - 1;

    // input capture
    logic [tsd_pkg::EV_W-1:0]   r_ev;
    logic [tsd_pkg::POS_W-1:0]  r_x;
    logic [tsd_pkg::POS_W-1:0]  r_y;
    logic [tsd_pkg::TIME_W-1:0] r_t;

    // touch state
    logic [tsd_pkg::THR_W-1:0]  r_thr;
    logic [AW-1:0]              r_newest;
    logic [CW-1:0]              r_count;
    logic                       r_lock;
    logic [tsd_pkg::GEST_W-1:0] r_gest;
    logic [tsd_pkg::VEL_W-1:0]  r_vel;

    // history ring
    logic [tsd_pkg::ENTRY_W-1:0] mem [HISTORY_DEPTH];
    logic [tsd_pkg::ENTRY_W-1:0] r_rd_data;
    logic [AW-1:0]               r_ptr;
    logic [CW-1:0]               r_left;
    logic                        r_issue_first;
    logic                        r_rd_vld;
    logic                        r_rd_first;

    // walk results
    logic [tsd_pkg::POS_W-1:0]   r_nx;
    logic [tsd_pkg::POS_W-1:0]   r_ny;
    logic [tsd_pkg::TIME_W-1:0]  r_tnew;
    logic [tsd_pkg::TIME_W-1:0]  r_told;
    logic signed [SUM_W-1:0]     r_sx;
    logic signed [SUM_W-1:0]     r_sy;

    // output register
    logic                            r_out_vld;
    logic [tsd_pkg::OUT_DATA_W-1:0]  r_out_data;

    logic                        push;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               newest_inc;
    logic [tsd_pkg::POS_W-1:0]   rd_x;
    logic [tsd_pkg::POS_W-1:0]   rd_y;
    logic [tsd_pkg::TIME_W-1:0]  rd_t;
    logic signed [tsd_pkg::POS_W:0] diff_x;
    logic signed [tsd_pkg::POS_W:0] diff_y;
    logic [SUM_W-1:0]            mag_x;
    logic [SUM_W-1:0]            mag_y;
    logic [SUM_W-1:0]            thr_x;
    logic                        axis_x;
    logic                        neg;
    logic [SUM_W-1:0]            mag_axis;
    logic [tsd_pkg::TIME_W-1:0]  span;
    logic                        div_busy;
    logic [DIVD_W-1:0]           div_quo;
    logic [QX_W-1:0]             quo_x;
    logic [tsd_pkg::VEL_W-1:0]   vel_sat;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ev <= i_event;
            r_x  <= i_pos_x;
            r_y  <= i_pos_y;
            r_t  <= i_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= tsd_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign newest_inc = (r_newest == AW'(HISTORY_DEPTH - 1)) ? '0 : r_newest + 1'b1;
    assign push       = i_cmd.update && (r_ev == tsd_pkg::EV_PRESS || r_ev == tsd_pkg::EV_MOVE);
    assign wr_addr    = (r_ev == tsd_pkg::EV_PRESS || r_count == '0) ? '0 : newest_inc;

    assign rd_x = r_rd_data[tsd_pkg::POS_W-1:0];
    assign rd_y = r_rd_data[2*tsd_pkg::POS_W-1:tsd_pkg::POS_W];
    assign rd_t = r_rd_data[tsd_pkg::ENTRY_W-1:2*tsd_pkg::POS_W];

    assign diff_x = $signed({1'b0, r_nx}) - $signed({1'b0, rd_x});
    assign diff_y = $signed({1'b0, r_ny}) - $signed({1'b0, rd_y});

    assign mag_x  = r_sx[SUM_W-1] ? SUM_W'(-r_sx) : SUM_W'(r_sx);
    assign mag_y  = r_sy[SUM_W-1] ? SUM_W'(-r_sy) : SUM_W'(r_sy);
    assign thr_x  = SUM_W'(r_thr);

    // velocity inputs follow the locked gesture's axis
    assign axis_x   = (r_gest == tsd_pkg::GEST_RIGHT || r_gest == tsd_pkg::GEST_LEFT);
    assign neg      = axis_x ? r_sx[SUM_W-1] : r_sy[SUM_W-1];
    assign mag_axis = axis_x ? mag_x : mag_y;
    assign span     = r_tnew - r_told;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_count  <= '0;
            r_lock   <= 1'b0;
            r_gest   <= tsd_pkg::GEST_NONE;
            r_vel    <= '0;
        end else if (i_cmd.update) begin
            case (r_ev)
                tsd_pkg::EV_RELEASE: begin
                    r_newest <= '0;
                    r_count  <= '0;
                    r_lock   <= 1'b0;
                    r_gest   <= tsd_pkg::GEST_NONE;
                    r_vel    <= '0;
                end
                tsd_pkg::EV_PRESS: begin
                    r_newest <= '0;
                    r_count  <= CW'(1);
                    r_lock   <= 1'b0;
                    r_gest   <= tsd_pkg::GEST_NONE;
                    r_vel    <= '0;
                end
                tsd_pkg::EV_MOVE: begin
                    r_newest <= wr_addr;
                    if (r_count != CW'(HISTORY_DEPTH)) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.classify && !r_lock) begin
            // a tie in magnitude goes to the y axis
            if (mag_x > mag_y) begin
                if (mag_x > thr_x) begin
                    r_lock <= 1'b1;
                    r_gest <= r_sx[SUM_W-1] ? tsd_pkg::GEST_LEFT : tsd_pkg::GEST_RIGHT;
                end
            end else if (mag_y > thr_x) begin
                r_lock <= 1'b1;
                r_gest <= r_sy[SUM_W-1] ? tsd_pkg::GEST_UP : tsd_pkg::GEST_DOWN;
            end
        end else if (i_cmd.vel_load) begin
            r_vel <= (span == '0) ? '0 : vel_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[wr_addr] <= {r_t, r_y, r_x};
        end
        r_rd_data <= mem[r_ptr];
    end

    // walk newest to oldest, one read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left        <= '0;
            r_rd_vld      <= 1'b0;
            r_issue_first <= 1'b0;
            r_rd_first    <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_left        <= r_count;
            r_rd_vld      <= 1'b0;
            r_issue_first <= 1'b1;
        end else begin
            r_rd_vld <= (r_left != '0);
            if (r_left != '0) begin
                r_left        <= r_left - 1'b1;
                r_rd_first    <= r_issue_first;
                r_issue_first <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_ptr <= r_newest;
        end else if (r_left != '0) begin
            r_ptr <= (r_ptr == '0) ? AW'(HISTORY_DEPTH - 1) : r_ptr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_sx <= '0;
            r_sy <= '0;
        end else if (r_rd_vld) begin
            r_told <= rd_t;
            if (r_rd_first) begin
                r_nx   <= rd_x;
                r_ny   <= rd_y;
                r_tnew <= rd_t;
            end else begin
                r_sx <= r_sx + SUM_W'(diff_x);
                r_sy <= r_sy + SUM_W'(diff_y);
            end
        end
    end

    tsd_div #(
        .DIVD_W (DIVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({mag_axis[MAG_W-1:0], {tsd_pkg::Q_FRAC{1'b0}}}),
        .i_divisor  (span),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign quo_x = QX_W'(div_quo);

    always_comb begin
        if (!neg) begin
            vel_sat = (quo_x > QX_W'(tsd_pkg::VEL_MAX)) ? tsd_pkg::VEL_MAX
                                                        : quo_x[tsd_pkg::VEL_W-1:0];
        end else begin
            vel_sat = (quo_x > QX_W'(tsd_pkg::VEL_MIN)) ? tsd_pkg::VEL_MIN
                                                        : -quo_x[tsd_pkg::VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {{PAD_W{1'b0}}, r_lock, r_vel, r_gest};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    assign o_stat.enough_pts = (int'(r_count) > MIN_POINTS);
    assign o_stat.walk_done  = (r_left == '0) && !r_rd_vld;
    assign o_stat.locked     = r_lock;
    assign o_stat.span_zero  = (span == '0);
    assign o_stat.div_busy   = div_busy;
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

endmodule

`default_nettype wire

@@ hdl/touch_swipe_detector.sv @@
// From input transfer to output register, a report with at most MIN_POINTS points held skips
// the walk of the history ring; with more points the ring is walked, one entry per cycle,
// and only a locked gesture with a nonzero time span runs the divider, one bit per cycle.
// One report at a time: tready returns when the result enters the output register, and a
// stalled output register holds it off.
// Reset (synchronous, active low) empties the history, clears lock, gesture and velocity.
`default_nettype none

module touch_swipe_detector #(
    parameter int HISTORY_DEPTH = 16,
    parameter int MIN_POINTS    = 5
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [11:0] pos_x, [23:12] pos_y, [55:24] time_ms
    input  wire  [tsd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [1:0] touch_event, rest zero
    input  wire  [tsd_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // [2:0] gesture, [34:3] velocity, [35] locked, rest zero
    output logic [tsd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  wire                               i_cfg_we,
    input  wire  [tsd_pkg::THR_W-1:0]         i_cfg_wdata
);

    tsd_pkg::t_cmd  cmd;
    tsd_pkg::t_stat stat;
    logic           in_ready;
    logic           accept;

    assign accept          = i_s_axis_tvalid && in_ready;
    assign o_s_axis_tready = in_ready;

    tsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    tsd_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MIN_POINTS    (MIN_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_event     (i_s_axis_tuser[tsd_pkg::EV_W-1:0]),
        .i_pos_x     (i_s_axis_tdata[11:0]),
        .i_pos_y     (i_s_axis_tdata[23:12]),
        .i_time      (i_s_axis_tdata[55:24]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ hdl/tsd_chk.sv @@
// Port-level checks of the swipe detector, bound to the top level.
`default_nettype none

module tsd_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_axis_tvalid,
    input wire                             o_s_axis_tready,
    input wire                             o_m_axis_tvalid,
    input wire                             i_m_axis_tready,
    input wire [tsd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    // held result must not vanish before its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // one report in flight: input closes right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second report taken while busy");

    a_unlocked_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[35] |->
            o_m_axis_tdata[2:0] == tsd_pkg::GEST_NONE && o_m_axis_tdata[34:3] == 32'd0)
        else $error("gesture or velocity without lock");

    a_locked_gest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[35] |->
            o_m_axis_tdata[2:0] == tsd_pkg::GEST_RIGHT || o_m_axis_tdata[2:0] == tsd_pkg::GEST_LEFT
            || o_m_axis_tdata[2:0] == tsd_pkg::GEST_DOWN || o_m_axis_tdata[2:0] == tsd_pkg::GEST_UP)
        else $error("lock without a swipe direction");

endmodule

bind touch_swipe_detector tsd_chk u_tsd_chk (.*);

`default_nettype wire
